// ===== hdl/lkc_pkg.sv =====
package lkc_pkg;

   localparam int ENTRIES = 64;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SLOT_W  = 6;
   localparam int KEY_W   = 32;
   localparam int COST_W  = 16;
   localparam int STAMP_W = 64;
   localparam int STATUS_W = 3;

   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [KEY_W-1:0]    key_type;
   typedef logic [COST_W-1:0]   cost_type;
   typedef logic [STAMP_W-1:0]  stamp_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_HIT     = 3'd0;
   localparam status_type ST_MISS    = 3'd1;
   localparam status_type ST_UPDATED = 3'd2;
   localparam status_type ST_FILLED  = 3'd3;
   localparam status_type ST_EVICTED = 3'd4;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   typedef struct packed {
      logic     mode;
      key_type  key;
      cost_type latency_in;
      cost_type energy_in;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      cost_type          latency_out;
      cost_type          energy_out;
   } rsp_type;

   // Search record that walks down the row of cells, one cell per cycle.
   typedef struct packed {
      logic      active;
      key_type   key;
      logic      hit;
      idx_type   hit_idx;
      cost_type  hit_lat;
      cost_type  hit_eng;
      logic      free;
      idx_type   free_idx;
      logic      old;
      stamp_type old_stamp;
      idx_type   old_idx;
   } tok_type;

   // Write broadcast to every cell; only the addressed cell takes it.
   typedef struct packed {
      logic      en;
      logic      full;
      idx_type   slot;
      key_type   key;
      cost_type  lat;
      cost_type  eng;
      stamp_type stamp;
   } wr_type;

endpackage

// ===== hdl/lru_keyed_cost_cache.sv =====
// Channel  | Direction | Ports                              | Content
// request  | in        | req_valid, req_stall, req_payload  | mode, key, costs to store
// response | out       | rsp_valid, rsp_stall, rsp_payload  | status, slot, stored costs
//
// One transaction at a time: the search record walks the row of cells one per cycle,
// its result is registered, then it enters the response register from the final state.
// A new request is taken once the previous result has entered the response register.
// Reset is synchronous; it clears all valid marks and the use clock.
// A stalled response holds the block in its final state until the register is free.
module lru_keyed_cost_cache (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lkc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lkc_pkg::rsp_type rsp_payload
);
   import lkc_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_type;

   state_type state_ff;
   req_type   req_ff;
   rsp_type   res_ff;
   rsp_type   rsp_ff;
   logic      rsp_valid_ff;
   idx_type   wr_slot_ff;
   logic      wr_full_ff;
   logic      wr_do_ff;
   stamp_type clock_ff;

   tok_type   chain [ENTRIES+1];
   tok_type   head;
   tok_type   tail;
   wr_type    wr;
   logic      finish;

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign finish      = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign tail        = chain[ENTRIES];
   assign chain[0]    = head;

   always_comb begin
      head        = '0;
      head.active = (state_ff == S_IDLE) && req_valid;
      head.key    = req_payload.key;
   end

   always_comb begin
      wr.en    = finish && wr_do_ff;
      wr.full  = wr_full_ff;
      wr.slot  = wr_slot_ff;
      wr.key   = req_ff.key;
      wr.lat   = req_ff.latency_in;
      wr.eng   = req_ff.energy_in;
      wr.stamp = clock_ff + STAMP_W'(1);
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lkc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (idx_type'(i)),
         .tok_prev (chain[i]),
         .tok_next (chain[i+1]),
         .wr       (wr)
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         clock_ff     <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !finish) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_payload;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (tail.active) begin
                  if (req_ff.mode == MODE_LOOKUP) begin
                     wr_full_ff <= 1'b0;
                     wr_slot_ff <= tail.hit_idx;
                     wr_do_ff   <= tail.hit;
                     if (tail.hit) begin
                        res_ff.status      <= ST_HIT;
                        res_ff.slot        <= SLOT_W'(tail.hit_idx);
                        res_ff.latency_out <= tail.hit_lat;
                        res_ff.energy_out  <= tail.hit_eng;
                     end else begin
                        res_ff.status      <= ST_MISS;
                        res_ff.slot        <= '0;
                        res_ff.latency_out <= '0;
                        res_ff.energy_out  <= '0;
                     end
                  end else begin
                     res_ff.latency_out <= '0;
                     res_ff.energy_out  <= '0;
                     wr_full_ff <= 1'b1;
                     wr_do_ff   <= 1'b1;
                     priority if (tail.hit) begin
                        res_ff.status <= ST_UPDATED;
                        res_ff.slot   <= SLOT_W'(tail.hit_idx);
                        wr_slot_ff    <= tail.hit_idx;
                     end else if (tail.free) begin
                        res_ff.status <= ST_FILLED;
                        res_ff.slot   <= SLOT_W'(tail.free_idx);
                        wr_slot_ff    <= tail.free_idx;
                     end else begin
                        res_ff.status <= ST_EVICTED;
                        res_ff.slot   <= SLOT_W'(tail.old_idx);
                        wr_slot_ff    <= tail.old_idx;
                     end
                  end
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (finish) begin
                  rsp_ff       <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  if (wr_do_ff) begin
                     clock_ff <= clock_ff + STAMP_W'(1);
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== hdl/lkc_cell.sv =====
module lkc_cell (
   input  logic             clock,
   input  logic             reset,
   input  lkc_pkg::idx_type cell_idx,
   input  lkc_pkg::tok_type tok_prev,
   output lkc_pkg::tok_type tok_next,
   input  lkc_pkg::wr_type  wr
);
   import lkc_pkg::*;

   logic      valid_ff;
   key_type   key_ff;
   cost_type  lat_ff;
   cost_type  eng_ff;
   stamp_type stamp_ff;
   tok_type   tok_ff;
   tok_type   tok_in;

   always_comb begin
      tok_in = tok_prev;
      if (!tok_prev.hit && valid_ff && key_ff == tok_prev.key) begin
         tok_in.hit     = 1'b1;
         tok_in.hit_idx = cell_idx;
         tok_in.hit_lat = lat_ff;
         tok_in.hit_eng = eng_ff;
      end
      if (!tok_prev.free && !valid_ff) begin
         tok_in.free     = 1'b1;
         tok_in.free_idx = cell_idx;
      end
      // Strict compare keeps the lowest index on equal stamps.
      if (!tok_prev.old || stamp_ff < tok_prev.old_stamp) begin
         tok_in.old       = 1'b1;
         tok_in.old_stamp = stamp_ff;
         tok_in.old_idx   = cell_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff <= tok_in;
         if (wr.en && wr.slot == cell_idx) begin
            stamp_ff <= wr.stamp;
            if (wr.full) begin
               valid_ff <= 1'b1;
               key_ff   <= wr.key;
               lat_ff   <= wr.lat;
               eng_ff   <= wr.eng;
            end
         end
      end
   end

   assign tok_next = tok_ff;

endmodule

// ===== hdl/lkc_checker.sv =====
module lkc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lkc_pkg::rsp_type rsp_payload
);
   import lkc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status <= ST_EVICTED)
      else $error("response status out of range");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_MISS |->
         rsp_payload.slot == '0 && rsp_payload.latency_out == '0 &&
         rsp_payload.energy_out == '0)
      else $error("lookup miss carries data");

   a_insert_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == ST_UPDATED || rsp_payload.status == ST_FILLED ||
         rsp_payload.status == ST_EVICTED) |->
         rsp_payload.latency_out == '0 && rsp_payload.energy_out == '0)
      else $error("insert response carries costs");

   a_new_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response issued while the block was idle");

endmodule

bind lru_keyed_cost_cache lkc_checker u_lkc_checker (.*);

// ===== tb/tb.sv =====
module tb;
   import lkc_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   lru_keyed_cost_cache u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   // Cache predictor state.
   bit        line_valid [ENTRIES];
   key_type   line_key   [ENTRIES];
   cost_type  line_lat   [ENTRIES];
   cost_type  line_eng   [ENTRIES];
   stamp_type line_stamp [ENTRIES];
   stamp_type lru_clock;

   rsp_type   pending_rsp[$];
   int        mismatch_count;
   int        burst_left;
   bit        hold_off;
   int        hold_cycles;
   key_type   recent_keys[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic rsp_type predict_cache(req_type rq);
      rsp_type r;
      int      s;
      r = '0;
      s = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (s < 0 && line_valid[i] && line_key[i] == rq.key) s = i;
      if (rq.mode == MODE_LOOKUP) begin
         if (s < 0) begin
            r.status = ST_MISS;
            s = 0;
         end else begin
            r.status      = ST_HIT;
            r.latency_out = line_lat[s];
            r.energy_out  = line_eng[s];
            lru_clock++;
            line_stamp[s] = lru_clock;
         end
      end else begin
         lru_clock++;
         if (s >= 0) begin
            r.status = ST_UPDATED;
         end else begin
            for (int i = 0; i < ENTRIES; i++)
               if (s < 0 && !line_valid[i]) s = i;
            if (s >= 0) begin
               r.status = ST_FILLED;
            end else begin
               s = 0;
               for (int i = 1; i < ENTRIES; i++)
                  if (line_stamp[i] < line_stamp[s]) s = i;
               r.status = ST_EVICTED;
            end
         end
         line_key[s]   = rq.key;
         line_lat[s]   = rq.latency_in;
         line_eng[s]   = rq.energy_in;
         line_stamp[s] = lru_clock;
         line_valid[s] = 1'b1;
      end
      r.slot = s[5:0];
      return r;
   endfunction

   // Holds one transaction on the request channel until it is accepted.
   task automatic send_req(logic mode, key_type k, cost_type lat, cost_type eng);
      req_type rq;
      int      gap;
      rq.mode = mode;
      rq.key = k;
      rq.latency_in = lat;
      rq.energy_in = eng;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= rq;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(predict_cache(rq));
      if (recent_keys.size() > 80) void'(recent_keys.pop_front());
      recent_keys.push_back(k);
   endtask

   function automatic key_type pick_key();
      if (recent_keys.size() > 0 && $urandom_range(0, 3) != 0)
         return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      return $urandom();
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response %p", rsp_payload);
         end else begin
            rsp_type e;
            e = pending_rsp.pop_front();
            if (rsp_payload.status !== e.status || rsp_payload.slot !== e.slot ||
                rsp_payload.latency_out !== e.latency_out ||
                rsp_payload.energy_out !== e.energy_out) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p actual %p", e, rsp_payload);
            end
         end
      end
   end

   // The receiver stalls on its own pattern, with one long hold-off on request.
   always @(posedge clock) begin
      if (hold_off) begin
         rsp_stall <= 1'b1;
         hold_cycles++;
         if (hold_cycles >= 400) hold_off <= 1'b0;
      end else if (($urandom_range(0, 255) & 8'hC0) == 0) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   task automatic test_directed();
      send_req(MODE_LOOKUP, 32'h0, 16'h0, 16'h0);
      send_req(MODE_INSERT, 32'h0, 16'h0, 16'h0);
      send_req(MODE_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_req(MODE_LOOKUP, 32'hFFFF_FFFF, 16'h1234, 16'h5678);
      send_req(MODE_LOOKUP, 32'h0, 16'hFFFF, 16'hFFFF);
      send_req(MODE_INSERT, 32'h0, 16'hAAAA, 16'h5555);
      send_req(MODE_LOOKUP, 32'h0, 16'h0, 16'h0);
      send_req(MODE_LOOKUP, 32'h1234_5678, 16'h0, 16'h0);
      send_req(MODE_INSERT, 32'h8000_0000, 16'h8000, 16'h0001);
      send_req(MODE_LOOKUP, 32'h8000_0000, 16'h0, 16'h0);
   endtask

   // Fills every slot, then forces evictions and checks LRU order after a hit.
   task automatic test_fill_and_evict();
      for (int i = 0; i < ENTRIES + 4; i++)
         send_req(MODE_INSERT, 32'hC000_0000 + i, cost_type'($urandom()),
                  cost_type'($urandom()));
      send_req(MODE_LOOKUP, 32'hC000_0010, 16'h0, 16'h0);
      for (int i = 0; i < 6; i++)
         send_req(MODE_INSERT, 32'hD000_0000 + i, cost_type'($urandom()),
                  cost_type'($urandom()));
   endtask

   task automatic test_long_hold_off();
      hold_cycles = 0;
      hold_off = 1'b1;
      for (int i = 0; i < 20; i++)
         send_req(1'($urandom_range(0, 1)), pick_key(), cost_type'($urandom()),
                  cost_type'($urandom()));
   endtask

   task automatic test_random();
      for (int i = 0; i < 1700; i++)
         send_req(1'($urandom_range(0, 1)), pick_key(), cost_type'($urandom()),
                  cost_type'($urandom()));
   endtask

   initial begin
      int waited;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      hold_off = 1'b0;
      hold_cycles = 0;
      burst_left = 0;
      mismatch_count = 0;
      lru_clock = '0;
      for (int i = 0; i < ENTRIES; i++) line_valid[i] = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_and_evict();
      test_long_hold_off();
      test_random();
      req_valid <= 1'b0;
      waited = 0;
      while (pending_rsp.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (ENTRIES + 10) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
